### rtl/clock_gate_and_rate_control_defines.svh
// ----------------------------------------------------------------------------
// clock_gate_and_rate_control_defines
// Assertion macros shared by the clock controller RTL.
// ----------------------------------------------------------------------------
`ifndef CLOCK_GATE_AND_RATE_CONTROL_DEFINES_SVH
`define CLOCK_GATE_AND_RATE_CONTROL_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CGRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CGRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CGRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CGRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/cgrc_pkg.sv
// ----------------------------------------------------------------------------
// cgrc_pkg
// Types and constants of the clock gate and rate controller.
// ----------------------------------------------------------------------------
package cgrc_pkg;

    localparam int OSC_FREQ_HZ = 30000000;
    localparam int GATE_BITS   = 16;
    localparam int MAX_INDEX   = 16;
    localparam int MAX_MULT    = 10;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 5;
    localparam int OUT_W    = 16;
    localparam int FREQ_W   = 32;
    localparam int MULT_W   = 4;
    localparam int PRESC_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENABLE  = 2'd0,
        CMD_DISABLE = 2'd1,
        CMD_QUERY   = 2'd2,
        CMD_RESTORE = 2'd3
    } gate_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLL_MULT   = 2'd0,
        REG_PLL_IN_USE = 2'd1,
        REG_LS_PRESC   = 2'd2,
        REG_HS_PRESC   = 2'd3
    } cfg_reg_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic accept;
    } ctrl_cmd_t;

endpackage

### rtl/cgrc_ctrl.sv
// ----------------------------------------------------------------------------
// cgrc_ctrl
// Sequencer: refreshes the clock rates after reset or a register write and
// accepts gate commands while idle.
// ----------------------------------------------------------------------------
module cgrc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                wr_en,
    output logic                busy,
    output logic                done,
    output cgrc_pkg::ctrl_cmd_t cmd
);
    import cgrc_pkg::*;

    localparam int CNT_W = $clog2(FREQ_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic             last_step;

    assign last_step = (cnt_reg == CNT_W'(FREQ_W - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (wr_en)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cnt_next = '0;
                if (!wr_en)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (wr_en)
                begin
                    state_next = ST_LOAD;
                end
                else if (last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd.load   = (state_reg == ST_LOAD);
        cmd.step   = (state_reg == ST_DIV);
        cmd.accept = start && (state_reg == ST_IDLE);
        done_next  = cmd.accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

### rtl/cgrc_dp.sv
// ----------------------------------------------------------------------------
// cgrc_dp
// Datapath: configuration registers, gate mask, result registers and two
// bit-serial dividers for the peripheral clock rates.
// ----------------------------------------------------------------------------
module cgrc_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cgrc_pkg::ctrl_cmd_t           cmd,
    input  logic                          wr_en,
    input  logic [cgrc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [cgrc_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic [cgrc_pkg::CMD_W-1:0]    command,
    input  logic [cgrc_pkg::IDX_W-1:0]    peripheral_index,
    input  logic [cgrc_pkg::OUT_W-1:0]    restore_value,
    output logic                          accepted,
    output logic [cgrc_pkg::OUT_W-1:0]    gate_status,
    output logic [cgrc_pkg::OUT_W-1:0]    gate_mask,
    output logic [cgrc_pkg::FREQ_W-1:0]   main_clock_hz,
    output logic [cgrc_pkg::FREQ_W-1:0]   low_speed_clock_hz,
    output logic [cgrc_pkg::FREQ_W-1:0]   high_speed_clock_hz
);
    import cgrc_pkg::*;

    typedef struct packed {
        logic [PRESC_W-1:0] rem;
        logic [FREQ_W-1:0]  quo;
    } div_lane_t;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic div_lane_t div_step(div_lane_t cur, logic [PRESC_W-1:0] code);
        logic [PRESC_W:0] trial;
        div_lane_t        nxt;
        trial   = {cur.rem, cur.quo[FREQ_W-1]};
        nxt.quo = {cur.quo[FREQ_W-2:0], 1'b0};
        if (trial >= {1'b0, code})
        begin
            nxt.rem    = PRESC_W'(trial - {1'b0, code});
            nxt.quo[0] = 1'b1;
        end
        else
        begin
            nxt.rem = PRESC_W'(trial);
        end
        return nxt;
    endfunction

    logic [MULT_W-1:0]  mult_reg;
    logic               pll_in_use_reg;
    logic [PRESC_W-1:0] ls_presc_reg, hs_presc_reg;
    logic [FREQ_W-1:0]  main_hz_reg;
    div_lane_t          ls_lane_reg, hs_lane_reg, ls_lane_next, hs_lane_next;
    logic [FREQ_W-1:0]  main_calc, pll_prod;

    logic [GATE_BITS-1:0] mask_reg, mask_next;
    logic [GATE_BITS-1:0] gate_bit, mask_calc;
    logic                 index_ok;
    logic                 accepted_reg;
    logic [OUT_W-1:0]     status_reg, status_next;

    // main clock from the configuration
    assign pll_prod = (FREQ_W'(mult_reg) * FREQ_W'(OSC_FREQ_HZ)) >> 1;

    always_comb
    begin
        if (!pll_in_use_reg)
        begin
            main_calc = FREQ_W'(OSC_FREQ_HZ);
        end
        else if (mult_reg < MULT_W'(2))
        begin
            main_calc = FREQ_W'(OSC_FREQ_HZ) >> 1;
        end
        else
        begin
            main_calc = pll_prod;
        end
    end

    always_comb
    begin
        ls_lane_next = div_step(ls_lane_reg, ls_presc_reg);
        hs_lane_next = div_step(hs_lane_reg, hs_presc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg       <= '0;
            pll_in_use_reg <= 1'b1;
            ls_presc_reg   <= '0;
            hs_presc_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_PLL_MULT:
                begin
                    if (MULT_W'(wr_data) <= MULT_W'(MAX_MULT))
                    begin
                        mult_reg <= MULT_W'(wr_data);
                    end
                end
                REG_PLL_IN_USE: pll_in_use_reg <= wr_data[0];
                REG_LS_PRESC:   ls_presc_reg   <= PRESC_W'(wr_data);
                REG_HS_PRESC:   hs_presc_reg   <= PRESC_W'(wr_data);
                default:        ;
            endcase
        end
    end

    // divide by twice the code: halve first, then divide by the code
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            main_hz_reg     <= main_calc;
            ls_lane_reg.rem <= '0;
            ls_lane_reg.quo <= main_calc >> 1;
            hs_lane_reg.rem <= '0;
            hs_lane_reg.quo <= main_calc >> 1;
        end
        else if (cmd.step)
        begin
            ls_lane_reg <= ls_lane_next;
            hs_lane_reg <= hs_lane_next;
        end
    end

    // gate command
    assign index_ok = (peripheral_index <= IDX_W'(MAX_INDEX));

    always_comb
    begin
        gate_bit = '0;
        if ((IDX_W + 1)'(peripheral_index) < (IDX_W + 1)'(GATE_BITS))
        begin
            gate_bit = GATE_BITS'(1) << peripheral_index;
        end
    end

    always_comb
    begin
        case (gate_cmd_t'(command))
            CMD_ENABLE:  mask_calc = mask_reg | gate_bit;
            CMD_DISABLE: mask_calc = mask_reg & ~gate_bit;
            CMD_RESTORE: mask_calc = (mask_reg & ~gate_bit) | GATE_BITS'(restore_value);
            default:     mask_calc = mask_reg;
        endcase
        mask_next   = index_ok ? mask_calc : mask_reg;
        status_next = index_ok ? OUT_W'(mask_calc & gate_bit) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cmd.accept)
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            accepted_reg <= index_ok;
            status_reg   <= status_next;
        end
    end

    assign accepted            = accepted_reg;
    assign gate_status         = status_reg;
    assign gate_mask           = OUT_W'(mask_reg);
    assign main_clock_hz       = main_hz_reg;
    assign low_speed_clock_hz  = (ls_presc_reg == '0) ? main_hz_reg : ls_lane_reg.quo;
    assign high_speed_clock_hz = (hs_presc_reg == '0) ? main_hz_reg : hs_lane_reg.quo;

endmodule

### rtl/clock_gate_and_rate_control.sv
// a gate command accepted at one edge shows its result, with done high, in the next cycle
// throughput: one command per cycle while busy is low
// after reset and after every register write the rate dividers load and then compute
// all 32 quotient bits with busy high; the receiver cannot stall results
// reset: gate mask cleared, registers to defaults, rates recomputed
`include "clock_gate_and_rate_control_defines.svh"

// ----------------------------------------------------------------------------
// clock_gate_and_rate_control
// Peripheral clock gate mask with main and peripheral clock rate reporting.
// ----------------------------------------------------------------------------
module clock_gate_and_rate_control
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    output logic                            done,
    input  logic [cgrc_pkg::CMD_W-1:0]      command,
    input  logic [cgrc_pkg::IDX_W-1:0]      peripheral_index,
    input  logic [cgrc_pkg::OUT_W-1:0]      restore_value,
    output logic                            accepted,
    output logic [cgrc_pkg::OUT_W-1:0]      gate_status,
    output logic [cgrc_pkg::OUT_W-1:0]      gate_mask,
    output logic [cgrc_pkg::FREQ_W-1:0]     main_clock_hz,
    output logic [cgrc_pkg::FREQ_W-1:0]     low_speed_clock_hz,
    output logic [cgrc_pkg::FREQ_W-1:0]     high_speed_clock_hz,
    input  logic                            wr_en,
    input  logic [cgrc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [cgrc_pkg::CFG_DATA_W-1:0] wr_data
);
    import cgrc_pkg::*;

    ctrl_cmd_t cmd;

    cgrc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .wr_en (wr_en),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    cgrc_dp u_dp
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .wr_en               (wr_en),
        .wr_index            (wr_index),
        .wr_data             (wr_data),
        .command             (command),
        .peripheral_index    (peripheral_index),
        .restore_value       (restore_value),
        .accepted            (accepted),
        .gate_status         (gate_status),
        .gate_mask           (gate_mask),
        .main_clock_hz       (main_clock_hz),
        .low_speed_clock_hz  (low_speed_clock_hz),
        .high_speed_clock_hz (high_speed_clock_hz)
    );

    `CGRC_ASSERT_NXT(a_accept_done, clk, rst_n, start && !busy, done, "transaction without done")
    `CGRC_ASSERT_NXT(a_write_busy, clk, rst_n, wr_en, busy, "rates not refreshed after write")
    `CGRC_ASSERT_IMP(a_reject_status, clk, rst_n, done && !accepted, gate_status == '0,
                     "rejected transaction with gate status")

endmodule

### test/tb_clock_gate_and_rate_control.sv
// ----------------------------------------------------------------------------
// tb_clock_gate_and_rate_control
// Drives gate commands and register writes into the clock controller, predicts
// the gate mask and the reported clock rates for every transaction and checks
// each strobed result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_clock_gate_and_rate_control;

    timeunit 1ns;
    timeprecision 1ps;

    import cgrc_pkg::*;

    localparam int NUM_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic              ok;
        logic [OUT_W-1:0]  status;
        logic [OUT_W-1:0]  mask;
        logic [FREQ_W-1:0] main_hz;
        logic [FREQ_W-1:0] ls_hz;
        logic [FREQ_W-1:0] hs_hz;
    } gate_report_t;

    class gate_report_board;
        gate_report_t         pending_reports[$];
        logic [MULT_W-1:0]    pll_mult;
        logic                 pll_sel;
        logic [PRESC_W-1:0]   ls_code;
        logic [PRESC_W-1:0]   hs_code;
        logic [GATE_BITS-1:0] gates;
        int                   checked;
        int                   rejected;
        int                   mismatches;

        function new();
            pll_mult   = '0;
            pll_sel    = 1'b1;
            ls_code    = '0;
            hs_code    = '0;
            gates      = '0;
            checked    = 0;
            rejected   = 0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
            case (r)
                // out-of-range multiplier writes leave the register alone
                REG_PLL_MULT:   if (d <= MAX_MULT) pll_mult = d;
                REG_PLL_IN_USE: pll_sel = d[0];
                REG_LS_PRESC:   ls_code = d[PRESC_W-1:0];
                REG_HS_PRESC:   hs_code = d[PRESC_W-1:0];
                default:        ;
            endcase
        endfunction

        function logic [FREQ_W-1:0] clamp_rate(longint unsigned v);
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[FREQ_W-1:0];
        endfunction

        function longint unsigned core_rate();
            longint unsigned osc;
            osc = OSC_FREQ_HZ;
            if (!pll_sel)
                return osc;
            if (pll_mult < 2)
                return osc / 2;
            return (longint'(pll_mult) * osc) / 2;
        endfunction

        function longint unsigned divided_rate(longint unsigned m, logic [PRESC_W-1:0] code);
            if (code == 0)
                return m;
            return m / (2 * longint'(code));
        endfunction

        function void note_command(gate_cmd_t cmd, logic [IDX_W-1:0] idx,
                                   logic [OUT_W-1:0] rv);
            gate_report_t         exp;
            logic [GATE_BITS-1:0] bit_sel;
            longint unsigned      m;
            bit_sel = (idx < GATE_BITS) ? (GATE_BITS'(1) << idx) : '0;
            m = core_rate();
            exp.ok = (idx <= MAX_INDEX);
            exp.status = '0;
            if (exp.ok)
            begin
                case (cmd)
                    CMD_ENABLE:  gates = gates | bit_sel;
                    CMD_DISABLE: gates = gates & ~bit_sel;
                    CMD_RESTORE: gates = (gates & ~bit_sel) | rv;
                    default:     ;
                endcase
                exp.status = OUT_W'(gates & bit_sel);
            end
            else
                rejected++;
            exp.mask    = OUT_W'(gates);
            exp.main_hz = clamp_rate(m);
            exp.ls_hz   = clamp_rate(divided_rate(m, ls_code));
            exp.hs_hz   = clamp_rate(divided_rate(m, hs_code));
            pending_reports.push_back(exp);
        endfunction

        function void check_report(gate_report_t got);
            gate_report_t exp;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result with no command outstanding: ok=%0d status=%h mask=%h",
                             $time, got.ok, got.status, got.mask);
                return;
            end
            exp = pending_reports.pop_front();
            checked++;
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("[%0t] mismatch: exp ok=%0d status=%h mask=%h main=%0d ls=%0d hs=%0d",
                             $time, exp.ok, exp.status, exp.mask, exp.main_hz, exp.ls_hz,
                             exp.hs_hz);
                    $display("             got ok=%0d status=%h mask=%h main=%0d ls=%0d hs=%0d",
                             got.ok, got.status, got.mask, got.main_hz, got.ls_hz, got.hs_hz);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  done;
    logic [CMD_W-1:0]      command;
    logic [IDX_W-1:0]      peripheral_index;
    logic [OUT_W-1:0]      restore_value;
    logic                  accepted;
    logic [OUT_W-1:0]      gate_status;
    logic [OUT_W-1:0]      gate_mask;
    logic [FREQ_W-1:0]     main_clock_hz;
    logic [FREQ_W-1:0]     low_speed_clock_hz;
    logic [FREQ_W-1:0]     high_speed_clock_hz;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    gate_report_board sb;
    int               cycles;
    int               reg_writes;

    clock_gate_and_rate_control uut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .done                (done),
        .command             (command),
        .peripheral_index    (peripheral_index),
        .restore_value       (restore_value),
        .accepted            (accepted),
        .gate_status         (gate_status),
        .gate_mask           (gate_mask),
        .main_clock_hz       (main_clock_hz),
        .low_speed_clock_hz  (low_speed_clock_hz),
        .high_speed_clock_hz (high_speed_clock_hz),
        .wr_en               (wr_en),
        .wr_index            (wr_index),
        .wr_data             (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("clock_gate_and_rate_control verification failed");
            $finish;
        end
    end

    // results first: a command accepted at this edge reports in the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_report(gate_report_t'{accepted, gate_status, gate_mask,
                                               main_clock_hz, low_speed_clock_hz,
                                               high_speed_clock_hz});
            if (start && !busy)
                sb.note_command(gate_cmd_t'(command), peripheral_index, restore_value);
            if (wr_en)
                sb.write_reg(cfg_reg_t'(wr_index), wr_data);
        end
    end

    task automatic scramble_fields();
        command          = gate_cmd_t'($urandom_range(3));
        peripheral_index = IDX_W'($urandom_range(31));
        restore_value    = OUT_W'($urandom_range(16'hFFFF));
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic issue_command(gate_cmd_t cmd, logic [IDX_W-1:0] idx,
                                 logic [OUT_W-1:0] rv, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            scramble_fields();
            @(negedge clk);
        end
        start            = 1'b1;
        command          = cmd;
        peripheral_index = idx;
        restore_value    = rv;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic wait_for_reports();
        start = 1'b0;
        while (sb.pending_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
        start = 1'b0;
        while (busy)
            @(negedge clk);
        wr_en    = 1'b1;
        wr_index = r;
        wr_data  = d;
        @(negedge clk);
        wr_en    = 1'b0;
        wr_index = CFG_IDX_W'($urandom_range(3));
        wr_data  = CFG_DATA_W'($urandom_range(15));
        reg_writes++;
    endtask

    task automatic random_command(int idle_pct);
        gate_cmd_t        cmd;
        logic [IDX_W-1:0] idx;
        logic [OUT_W-1:0] rv;
        cmd = gate_cmd_t'($urandom_range(3));
        if ($urandom_range(99) < 80)
            idx = IDX_W'($urandom_range(MAX_INDEX));
        else
            idx = IDX_W'($urandom_range(31, MAX_INDEX + 1));
        // keep restores mostly sparse so the mask does not just saturate
        case ($urandom_range(3))
            0, 1:    rv = '0;
            2:       rv = OUT_W'($urandom_range(16'hFFFF));
            default: rv = OUT_W'(1) << $urandom_range(OUT_W - 1);
        endcase
        issue_command(cmd, idx, rv, idle_pct);
    endtask

    initial
    begin
        logic [MULT_W-1:0]  mult;
        logic               sel;
        logic [PRESC_W-1:0] ls;
        logic [PRESC_W-1:0] hs;
        int                 idle_pct;
        int                 drain_at;

        sb         = new();
        cycles     = 0;
        reg_writes = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = CMD_ENABLE;
        peripheral_index = '0;
        restore_value    = '0;
        wr_en      = 1'b0;
        wr_index   = REG_PLL_MULT;
        wr_data    = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, every command, rejected and bitless indexes
        issue_command(CMD_ENABLE,  5'd0,  16'h0000, 0);
        issue_command(CMD_ENABLE,  5'd15, 16'hFFFF, 0);
        issue_command(CMD_ENABLE,  5'd16, 16'h0000, 0);
        issue_command(CMD_QUERY,   5'd15, 16'h0000, 0);
        issue_command(CMD_QUERY,   5'd16, 16'hFFFF, 0);
        issue_command(CMD_QUERY,   5'd3,  16'h0000, 0);
        issue_command(CMD_DISABLE, 5'd15, 16'h0000, 0);
        issue_command(CMD_DISABLE, 5'd16, 16'h0000, 0);
        issue_command(CMD_ENABLE,  5'd31, 16'h0000, 0);
        issue_command(CMD_DISABLE, 5'd17, 16'h0000, 0);
        issue_command(CMD_QUERY,   5'd31, 16'h0000, 0);
        issue_command(CMD_RESTORE, 5'd17, 16'hFFFF, 0);
        issue_command(CMD_RESTORE, 5'd31, 16'hAAAA, 0);
        issue_command(CMD_RESTORE, 5'd16, 16'h8001, 0);
        issue_command(CMD_RESTORE, 5'd0,  16'h0000, 0);
        issue_command(CMD_RESTORE, 5'd5,  16'h0020, 0);
        issue_command(CMD_RESTORE, 5'd3,  16'hFFFF, 0);
        issue_command(CMD_QUERY,   5'd0,  16'h0000, 0);
        issue_command(CMD_DISABLE, 5'd0,  16'hFFFF, 0);
        issue_command(CMD_RESTORE, 5'd7,  16'h0000, 0);
        issue_command(CMD_DISABLE, 5'd10, 16'h0000, 0);
        issue_command(CMD_ENABLE,  5'd10, 16'h5555, 0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin mult = 4'd10; sel = 1'b1; ls = 3'd7; hs = 3'd0; end
                1: begin mult = 4'd1;  sel = 1'b1; ls = 3'd0; hs = 3'd7; end
                2: begin mult = 4'd2;  sel = 1'b0; ls = 3'd7; hs = 3'd7; end
                3: begin mult = 4'd0;  sel = 1'b1; ls = 3'd1; hs = 3'd1; end
                default:
                begin
                    mult = MULT_W'($urandom_range(MAX_MULT));
                    sel  = 1'($urandom_range(1));
                    ls   = PRESC_W'($urandom_range(7));
                    hs   = PRESC_W'($urandom_range(7));
                end
            endcase
            idle_pct = (p < 3) ? 24 : (p < 6) ? 78 : 0;

            wait_for_reports();
            write_register(REG_PLL_MULT, mult);
            // multipliers above ten must be ignored
            write_register(REG_PLL_MULT, CFG_DATA_W'($urandom_range(15, MAX_MULT + 1)));
            write_register(REG_PLL_IN_USE, {3'($urandom_range(7)), sel});
            write_register(REG_LS_PRESC, {1'($urandom_range(1)), ls});
            write_register(REG_HS_PRESC, {1'($urandom_range(1)), hs});

            drain_at = $urandom_range(ITEMS_PER_PHASE - 1, 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i == drain_at)
                    wait_for_reports();
                random_command(idle_pct);
            end
        end

        wait_for_reports();
        repeat (8) @(negedge clk);

        $display("checked %0d gate transactions (%0d with rejected index) across %0d rate settings",
                 sb.checked, sb.rejected, NUM_PHASES + 1);
        $display("%0d register writes, %0d mismatches, %0d results outstanding",
                 reg_writes, sb.mismatches, sb.pending_reports.size());
        if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
            $display("clock_gate_and_rate_control verification clean");
        else
            $display("clock_gate_and_rate_control verification failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/cgrc_pkg.sv
rtl/cgrc_ctrl.sv
rtl/cgrc_dp.sv
rtl/clock_gate_and_rate_control.sv
test/tb_clock_gate_and_rate_control.sv
